// ----- design/pcm_audio_fifo_device_macros.svh -----
// Assertion macros shared by the checker of the PCM audio FIFO device
`ifndef PCM_AUDIO_FIFO_DEVICE_MACROS_SVH
`define PCM_AUDIO_FIFO_DEVICE_MACROS_SVH

// same-cycle implication, quiet during reset
`define PAFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pafd check failed");

// next-cycle implication, quiet during reset
`define PAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pafd check failed");

`endif

// ----- design/pafd_pkg.sv -----
// Types and constants shared by the PCM audio FIFO device modules
`timescale 1ns / 1ps

package pafd_pkg;

    // byte FIFO; depth must be a power of two
    localparam int FIFO_DEPTH  = 4096;
    localparam int ADDR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int RATE_W      = 8;
    localparam logic [RATE_W-1:0] FULL_RATE = RATE_W'(128);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int FV_W           = 6;
    localparam int CTRL_CLEAR_BIT = 7;
    localparam int FV_WIDE_BIT    = 5;
    localparam int FV_STEREO_BIT  = 4;

    localparam int OUT_W = 48;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CTRL = 2'd0,
        REG_RATE = 2'd1,
        REG_DATA = 2'd2,
        REG_NONE = 2'd3
    } reg_sel_t;

    typedef enum logic [2:0] {
        OP_STATUS,
        OP_RD_CTRL,
        OP_WR_CTRL,
        OP_WR_RATE,
        OP_WR_DATA,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    // packed so that read_data sits in the lowest bits
    typedef struct packed {
        logic signed [15:0] right_sample;
        logic signed [15:0] left_sample;
        logic               sample_valid;
        logic               aflow;
        logic               fifo_empty;
        logic               fifo_full;
        logic [7:0]         read_data;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_EMIT
    } back_state_t;

endpackage

// ----- design/pafd_front.sv -----
// Front end: takes requests, classifies them and clamps the rate
`timescale 1ns / 1ps

module pafd_front import pafd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic [1:0] in_sel,
    input  logic [7:0] in_data,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op
);

    logic valid_reg;
    logic valid_next;
    op_t  op_reg;
    op_t  op_next;

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_comb
    begin
        op_next.data = in_data;
        unique case (cmd_t'(in_cmd))
            CMD_READ:
            begin
                op_next.kind = (reg_sel_t'(in_sel) == REG_CTRL) ? OP_RD_CTRL : OP_STATUS;
            end
            CMD_WRITE:
            begin
                unique case (reg_sel_t'(in_sel))
                    REG_CTRL: op_next.kind = OP_WR_CTRL;
                    REG_RATE:
                    begin
                        op_next.kind = OP_WR_RATE;
                        if (in_data > FULL_RATE)
                        begin
                            op_next.data = FULL_RATE;
                        end
                    end
                    REG_DATA: op_next.kind = OP_WR_DATA;
                    REG_NONE: op_next.kind = OP_STATUS;
                endcase
            end
            CMD_TICK: op_next.kind = OP_TICK;
            CMD_NONE: op_next.kind = OP_STATUS;
        endcase
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= op_next;
        end
    end

endmodule

// ----- design/pafd_queue.sv -----
// Short queue of classified requests between front and back
`timescale 1ns / 1ps

module pafd_queue import pafd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ----- design/pafd_back.sv -----
// Back end: registers, byte FIFO, sample clock and frame assembly
`timescale 1ns / 1ps

module pafd_back import pafd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    output logic    op_ready,
    input  op_t     op,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic [7:0]        mem [FIFO_DEPTH];
    logic [7:0]        mem_q;
    logic              mem_we;
    logic              mem_re;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] rp_reg;
    logic [ADDR_W-1:0] rp_next;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [FV_W-1:0]   fv_reg;
    logic [FV_W-1:0]   fv_next;
    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] rate_next;
    logic [RATE_W-1:0] acc_reg;
    logic [RATE_W-1:0] acc_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic [1:0]        last_reg;
    logic [1:0]        last_next;
    logic [7:0]        bytes_reg [4];
    logic [7:0]        bytes_next [4];
    result_t           res_reg;
    result_t           res_next;
    logic              mvalid_reg;
    logic              mvalid_next;

    logic              out_free;
    logic [RATE_W:0]   acc_sum;
    logic              due;
    logic              wide;
    logic              stereo;
    logic [2:0]        need;
    logic              have;
    logic              full_now;
    logic              empty_now;

    assign out_valid = mvalid_reg;
    assign result    = res_reg;
    assign out_free  = !mvalid_reg || out_ready;
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, rate_reg};
    assign due       = (rate_reg != '0) && (acc_sum >= {1'b0, FULL_RATE});
    assign wide      = fv_reg[FV_WIDE_BIT];
    assign stereo    = fv_reg[FV_STEREO_BIT];
    assign need      = wide ? (stereo ? 3'd4 : 3'd2) : (stereo ? 3'd2 : 3'd1);
    assign have      = fill_reg >= CNT_W'(need);
    assign full_now  = fill_reg == CNT_W'(FIFO_DEPTH);
    assign empty_now = fill_reg == '0;

    always_comb
    begin
        state_next  = state_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        fv_next     = fv_reg;
        rate_next   = rate_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        bytes_next  = bytes_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg && !out_ready;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        op_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                op_ready = out_free;
                if (op_valid && out_free)
                begin
                    res_next    = '0;
                    mvalid_next = 1'b1;
                    unique case (op.kind)
                        OP_RD_CTRL:
                        begin
                            res_next.read_data = {full_now, empty_now, fv_reg};
                        end
                        OP_WR_CTRL:
                        begin
                            fv_next = op.data[FV_W-1:0];
                            if (op.data[CTRL_CLEAR_BIT])
                            begin
                                rp_next   = '0;
                                wp_next   = '0;
                                fill_next = '0;
                            end
                        end
                        OP_WR_RATE:
                        begin
                            rate_next = op.data;
                        end
                        OP_WR_DATA:
                        begin
                            if (!full_now)
                            begin
                                mem_we    = 1'b1;
                                wp_next   = wp_reg + 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (rate_reg != '0)
                            begin
                                if (due)
                                begin
                                    acc_next              = RATE_W'(acc_sum - {1'b0, FULL_RATE});
                                    res_next.sample_valid = 1'b1;
                                    if (have)
                                    begin
                                        mem_re      = 1'b1;
                                        rp_next     = rp_reg + 1'b1;
                                        fill_next   = fill_reg - CNT_W'(need);
                                        idx_next    = '0;
                                        last_next   = 2'(need - 3'd1);
                                        state_next  = ST_POP;
                                        mvalid_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    acc_next = acc_sum[RATE_W-1:0];
                                end
                            end
                        end
                        OP_STATUS:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.fifo_full  = fill_next == CNT_W'(FIFO_DEPTH);
                    res_next.fifo_empty = fill_next == '0;
                    res_next.aflow      = fill_next < CNT_W'(FIFO_DEPTH / 4);
                end
            end
            ST_POP:
            begin
                bytes_next[idx_reg] = mem_q;
                if (idx_reg == last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_re   = 1'b1;
                    rp_next  = rp_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_next              = '0;
                    res_next.sample_valid = 1'b1;
                    if (wide)
                    begin
                        res_next.left_sample  = {bytes_reg[1], bytes_reg[0]};
                        res_next.right_sample = stereo ? {bytes_reg[3], bytes_reg[2]}
                                                       : {bytes_reg[1], bytes_reg[0]};
                    end
                    else
                    begin
                        res_next.left_sample  = {bytes_reg[0], 8'h00};
                        res_next.right_sample = stereo ? {bytes_reg[1], 8'h00}
                                                       : {bytes_reg[0], 8'h00};
                    end
                    res_next.fifo_full  = full_now;
                    res_next.fifo_empty = empty_now;
                    res_next.aflow      = fill_reg < CNT_W'(FIFO_DEPTH / 4);
                    mvalid_next         = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rp_reg     <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            fv_reg     <= '0;
            rate_reg   <= '0;
            acc_reg    <= '0;
            idx_reg    <= '0;
            last_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            fv_reg     <= fv_next;
            rate_reg   <= rate_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= op.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q <= mem[rp_reg];
        end
    end

endmodule

// ----- design/pcm_audio_fifo_device.sv -----
// PCM audio byte FIFO device: top level
`timescale 1ns / 1ps

// Slave channel: one request per handshake. tuser selects the operation
// (register read, register write, base sample tick) and the register
// (control, rate, data); tdata carries the written byte.
// Master channel: one result per request, with the read byte, FIFO status
// (full, empty, aflow) and, for a tick, the sample frame and its valid flag.
// A request passes the front register, the request queue and the back end's
// result register on its way to m_axis_tvalid; a tick that takes a frame also
// passes through ST_POP and ST_EMIT. Such a tick holds the back end until its
// frame is out, reading need bytes (need = 1, 2 or 4), one byte from the FIFO RAM
// each cycle; other requests go through at one per cycle while results are taken.
// A two-entry request queue lets the input side keep accepting while the
// back end reads bytes or the output waits.
// Reset empties the FIFO, clears format, volume and rate (playback stopped)
// and the phase accumulator; FIFO RAM contents are left as they are.
// A stalled receiver holds the result on m_axis; the back end then stops,
// the queue fills and s_axis_tready drops.

module pcm_audio_fifo_device import pafd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // write_data[7:0]
    input  logic [3:0]       s_axis_tuser,   // cmd[1:0], reg_sel[3:2]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // read_data[7:0], fifo_full[8], fifo_empty[9],
                                             // aflow[10], sample_valid[11],
                                             // left_sample[27:12], right_sample[43:28]
);

    logic    fq_valid;
    logic    fq_ready;
    op_t     fq_op;
    logic    qb_valid;
    logic    qb_ready;
    op_t     qb_op;
    result_t result;

    pafd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser[1:0]),
        .in_sel   (s_axis_tuser[3:2]),
        .in_data  (s_axis_tdata),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op       (fq_op)
    );

    pafd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_op     (fq_op),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_op    (qb_op)
    );

    pafd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (qb_valid),
        .op_ready  (qb_ready),
        .op        (qb_op),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {(OUT_W - $bits(result_t))'(0), result};

endmodule

// ----- design/pafd_checker.sv -----
// Port-level checks for the PCM audio FIFO device, bound to the top level
`timescale 1ns / 1ps

`include "pcm_audio_fifo_device_macros.svh"

module pafd_checker import pafd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [7:0]       s_axis_tdata,
    input logic [3:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // waiting request holds
    `PAFD_ASSERT_NEXT(a_in_hold, clk, rst_n, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tuser) && $stable(s_axis_tdata))
    // stalled result holds
    `PAFD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // full and empty never together
    `PAFD_ASSERT_NOW(a_full_empty, clk, rst_n, m_axis_tvalid, !(m_axis_tdata[8] && m_axis_tdata[9]))
    // no frame, no sample bits
    `PAFD_ASSERT_NOW(a_no_frame, clk, rst_n, m_axis_tvalid && !m_axis_tdata[11], m_axis_tdata[43:12] == '0)
    // aflow agrees with full and empty
    `PAFD_ASSERT_NOW(a_aflow, clk, rst_n, m_axis_tvalid, (!m_axis_tdata[8] || !m_axis_tdata[10]) && (!m_axis_tdata[9] || m_axis_tdata[10]))

endmodule

bind pcm_audio_fifo_device pafd_checker u_pafd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/pafd_stream_checker.sv -----
// Checker for the PCM audio FIFO device: predicts each response and compares it on m_axis
`timescale 1ns / 1ps

module pafd_stream_checker import pafd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic [3:0]       s_axis_tuser,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    output int               mismatches,
    output int               outstanding
);

    logic [7:0]        fifo_image [FIFO_DEPTH];
    logic [ADDR_W-1:0] wr_ptr;
    logic [ADDR_W-1:0] rd_ptr;
    logic [CNT_W-1:0]  level;
    logic [FV_W-1:0]   fmt_vol;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] phase;
    result_t           response_queue [$];

    task automatic take_byte(output logic [7:0] b);
        b = fifo_image[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        level = level - 1'b1;
    endtask

    task automatic take_sample(input bit wide, output logic [15:0] smp);
        logic [7:0] lo;
        logic [7:0] hi;
        take_byte(lo);
        if (wide)
        begin
            take_byte(hi);
            smp = {hi, lo};
        end
        else
        begin
            smp = {lo, 8'h00};
        end
    endtask

    task automatic compute_response(input cmd_t c, input reg_sel_t r, input logic [7:0] d,
                                    output result_t res);
        int          acc;
        int          need;
        bit          wide;
        bit          stereo;
        logic [15:0] lsmp;
        logic [15:0] rsmp;
        res = '0;
        case (c)
            CMD_READ:
            begin
                if (r == REG_CTRL)
                    res.read_data = {level == FIFO_DEPTH, level == 0, fmt_vol};
            end
            CMD_WRITE:
            begin
                case (r)
                    REG_CTRL:
                    begin
                        fmt_vol = d[FV_W-1:0];
                        if (d[CTRL_CLEAR_BIT])
                        begin
                            wr_ptr = '0;
                            rd_ptr = '0;
                            level  = '0;
                        end
                    end
                    REG_RATE: rate = (d > FULL_RATE) ? FULL_RATE : d;
                    REG_DATA:
                    begin
                        if (level < FIFO_DEPTH)
                        begin
                            fifo_image[wr_ptr] = d;
                            wr_ptr = wr_ptr + 1'b1;
                            level  = level + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_TICK:
            begin
                if (rate != 0)
                begin
                    acc = int'(phase) + int'(rate);
                    if (acc >= int'(FULL_RATE))
                    begin
                        wide   = fmt_vol[FV_WIDE_BIT];
                        stereo = fmt_vol[FV_STEREO_BIT];
                        need   = (wide ? 2 : 1) * (stereo ? 2 : 1);
                        acc    = acc - int'(FULL_RATE);
                        res.sample_valid = 1'b1;
                        // underrun: frame reported as silence, nothing consumed
                        if (int'(level) >= need)
                        begin
                            take_sample(wide, lsmp);
                            if (stereo)
                                take_sample(wide, rsmp);
                            else
                                rsmp = lsmp;
                            res.left_sample  = lsmp;
                            res.right_sample = rsmp;
                        end
                    end
                    phase = RATE_W'(acc);
                end
            end
            default: ;
        endcase
        res.fifo_full  = (level == FIFO_DEPTH);
        res.fifo_empty = (level == 0);
        res.aflow      = (level < FIFO_DEPTH / 4);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            wr_ptr  = '0;
            rd_ptr  = '0;
            level   = '0;
            fmt_vol = '0;
            rate    = '0;
            phase   = '0;
            response_queue.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (response_queue.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: response with no request outstanding: %h",
                                 $realtime, m_axis_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = response_queue.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch exp rd=%h f=%b e=%b af=%b v=%b l=%h r=%h",
                                      " / got rd=%h f=%b e=%b af=%b v=%b l=%h r=%h"},
                                     $realtime, want.read_data, want.fifo_full,
                                     want.fifo_empty, want.aflow, want.sample_valid,
                                     want.left_sample, want.right_sample,
                                     got.read_data, got.fifo_full, got.fifo_empty,
                                     got.aflow, got.sample_valid, got.left_sample,
                                     got.right_sample);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_response(cmd_t'(s_axis_tuser[1:0]), reg_sel_t'(s_axis_tuser[3:2]),
                                 s_axis_tdata, want);
                response_queue.push_back(want);
            end
            outstanding <= response_queue.size();
        end
    end

endmodule

// ----- sim/tb_pcm_audio_fifo_device.sv -----
// Testbench top for the PCM audio FIFO device: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module tb_pcm_audio_fifo_device;
    import pafd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;
    logic [3:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b1;
    logic [OUT_W-1:0] m_axis_tdata;
    int               mismatches;
    int               outstanding;
    int               quiet_cycles = 0;
    bit               gaps_on = 1'b1;

    pcm_audio_fifo_device u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pafd_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (gaps_on)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic issue_request(input cmd_t c, input reg_sel_t r, input logic [7:0] d);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {r, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic random_request();
        int         pick;
        logic [7:0] d;
        pick = $urandom_range(0, 99);
        d    = 8'($urandom);
        if (pick < 34)
            issue_request(CMD_WRITE, REG_DATA, d);
        else if (pick < 68)
            issue_request(CMD_TICK, reg_sel_t'($urandom_range(0, 3)), d);
        else if (pick < 76)
        begin
            if ($urandom_range(0, 5) != 0)
                d[CTRL_CLEAR_BIT] = 1'b0;
            issue_request(CMD_WRITE, REG_CTRL, d);
        end
        else if (pick < 83)
        begin
            case ($urandom_range(0, 3))
                0: d = FULL_RATE;
                1: d = 8'($urandom_range(1, 16));
                default: ;
            endcase
            issue_request(CMD_WRITE, REG_RATE, d);
        end
        else if (pick < 93)
            issue_request(CMD_READ, reg_sel_t'($urandom_range(0, 3)), d);
        else if (pick < 97)
            issue_request(CMD_WRITE, REG_NONE, d);
        else
            issue_request(CMD_NONE, reg_sel_t'($urandom_range(0, 3)), d);
    endtask

    initial
    begin
        int i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register reads, rate clamp, formats, underrun, clear
        issue_request(CMD_READ, REG_CTRL, 8'h00);
        issue_request(CMD_READ, REG_RATE, 8'hFF);
        issue_request(CMD_READ, REG_DATA, 8'h00);
        issue_request(CMD_READ, REG_NONE, 8'hFF);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_RATE, 8'hC8);
        issue_request(CMD_READ, REG_RATE, 8'h00);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_DATA, 8'h80);
        issue_request(CMD_WRITE, REG_DATA, 8'h7F);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_CTRL, 8'h10);
        issue_request(CMD_WRITE, REG_DATA, 8'hFF);
        issue_request(CMD_WRITE, REG_DATA, 8'h01);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_CTRL, 8'h20);
        issue_request(CMD_WRITE, REG_DATA, 8'h00);
        issue_request(CMD_WRITE, REG_DATA, 8'h80);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_CTRL, 8'h7F);
        issue_request(CMD_READ, REG_CTRL, 8'h00);
        for (i = 0; i < 3; i++)
            issue_request(CMD_WRITE, REG_DATA, 8'($urandom));
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_DATA, 8'hA5);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);
        issue_request(CMD_WRITE, REG_CTRL, 8'hBF);
        issue_request(CMD_READ, REG_CTRL, 8'h00);
        issue_request(CMD_NONE, REG_NONE, 8'hFF);
        issue_request(CMD_WRITE, REG_NONE, 8'hFF);
        issue_request(CMD_WRITE, REG_RATE, 8'h01);
        issue_request(CMD_TICK, REG_CTRL, 8'h00);

        for (i = 0; i < 356; i++)
            random_request();

        for (i = 0; i < 100; i++)
            random_request();

        gaps_on = 1'b0;
        for (i = 0; i < 60; i++)
            random_request();
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
